@@ hdl/crd_pkg.sv @@
// Shared types, codes and the CRC-32 byte update for the record deframer.
`default_nettype none
package crd_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_RECORD_MAGIC  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_PAYLOAD   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BASE_POSITION = 2'd2;

  localparam logic [31:0] MAGIC_RST       = 32'h0000_0000;
  localparam logic [31:0] MAX_PAYLOAD_RST = 32'h0010_0000;
  localparam logic [63:0] BASE_POS_RST    = 64'h0;

  localparam logic       KIND_PAYLOAD = 1'b0;
  localparam logic       KIND_STATUS  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EOF     = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic        last_payload;
    logic [1:0]  status;
    logic [63:0] end_position;
  } res_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ hdl/crc_record_deframer_core.sv @@
// Top level: byte-serial deframer for length-prefixed records with CRC-32 check.
//
// Input channel: one request per byte (in_data_byte) or an end marker
// (in_end_of_input); in_expected_offset is sampled on the last offset byte.
// Result channel: payload bytes (kind 0) as they arrive, then one status
// (kind 1: ok, clean_eof or invalid) with the end position per record.
// Configuration: cfg_index / cfg_wdata written when cfg_valid, cfg_ready
// is always high; writing base_position also reloads the stream position.
// Throughput: one byte per cycle while in_stall is low. Each result is
// registered (in the skid register if the output is held); the CRC update,
// field shift and checks sit between the input and the output register.
// Stall: a two-entry output stage (output register plus skid register)
// keeps accepting while a result waits; in_stall rises only once the skid
// register holds a result, and drops when the receiver takes one.
// Reset: parser to the magic field, CRC to all ones, registers to their
// defaults, stream position to zero, output stage empty.
`default_nettype none
module crc_record_deframer_core
  import crd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire logic [7:0]          in_data_byte,
  input  wire logic                in_end_of_input,
  input  wire logic [63:0]         in_expected_offset,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      logic                out_kind,
  output      logic [7:0]          out_payload_byte,
  output      logic                out_last_payload,
  output      logic [1:0]          out_status,
  output      logic [63:0]         out_end_position,
  input  wire logic                cfg_valid,
  output      logic                cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [63:0]         cfg_wdata
);

  localparam logic [2:0] PH_MAGIC   = 3'd0;
  localparam logic [2:0] PH_OFFSET  = 3'd1;
  localparam logic [2:0] PH_LENGTH  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CRC     = 3'd4;

  logic [31:0] magic_r, max_pay_r;

  logic [2:0]  phase_r, phase_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [63:0] shift_r, shift_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [63:0] pos_r, pos_nxt;

  logic        out_valid_r, skd_valid_r;
  res_t        out_r, skd_r, res;
  logic        res_valid;

  logic        in_acc, out_fire;
  logic [63:0] pos_inc, shift_new;
  logic [2:0]  cnt_inc;
  logic [31:0] crc_upd;

  assign in_acc    = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;
  assign in_stall  = skd_valid_r;
  assign cfg_ready = 1'b1;

  assign pos_inc = pos_r + 64'd1;
  assign cnt_inc = cnt_r + 3'd1;
  assign crc_upd = crc_byte(crc_r, in_data_byte);

  always_comb begin
    shift_new = shift_r;
    shift_new[{cnt_r, 3'b000} +: 8] = in_data_byte;
  end

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    shift_nxt  = shift_r;
    remain_nxt = remain_r;
    crc_nxt    = crc_r;
    pos_nxt    = pos_r;
    res_valid  = 1'b0;
    res.kind         = KIND_STATUS;
    res.payload_byte = 8'h00;
    res.last_payload = 1'b0;
    res.status       = ST_INVALID;
    res.end_position = pos_inc;
    if (in_acc) begin
      if (in_end_of_input) begin
        res_valid        = 1'b1;
        res.end_position = pos_r;
        res.status       = (phase_r == PH_MAGIC && cnt_r == 3'd0) ? ST_EOF : ST_INVALID;
      end else begin
        pos_nxt   = pos_inc;
        cnt_nxt   = cnt_inc;
        shift_nxt = shift_new;
        unique case (phase_r)
          PH_MAGIC: begin
            if (cnt_inc == 3'd4) begin
              cnt_nxt   = 3'd0;
              shift_nxt = 64'h0;
              if (shift_new[31:0] != magic_r) res_valid = 1'b1;
              else phase_nxt = PH_OFFSET;
            end
          end
          PH_OFFSET: begin
            crc_nxt = crc_upd;
            if (cnt_inc == 3'd0) begin
              shift_nxt = 64'h0;
              if (shift_new != in_expected_offset) res_valid = 1'b1;
              else phase_nxt = PH_LENGTH;
            end
          end
          PH_LENGTH: begin
            crc_nxt = crc_upd;
            if (cnt_inc == 3'd0) begin
              shift_nxt = 64'h0;
              if (shift_new[63:32] != 32'h0 || shift_new[31:0] > max_pay_r) begin
                res_valid = 1'b1;
              end else begin
                remain_nxt = shift_new[31:0];
                phase_nxt  = (shift_new[31:0] == 32'h0) ? PH_CRC : PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            cnt_nxt          = cnt_r;
            shift_nxt        = shift_r;
            crc_nxt          = crc_upd;
            res_valid        = 1'b1;
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = in_data_byte;
            res.last_payload = (remain_r <= 32'd1);
            res.status       = ST_OK;
            res.end_position = 64'h0;
            if (remain_r != 32'd0) remain_nxt = remain_r - 32'd1;
            if (remain_r <= 32'd1) phase_nxt = PH_CRC;
          end
          PH_CRC: begin
            if (cnt_inc == 3'd4) begin
              res_valid  = 1'b1;
              res.status = ({in_data_byte, shift_r[23:0]} == ~crc_r) ? ST_OK : ST_INVALID;
            end
          end
          default: begin
            res_valid = 1'b1;
          end
        endcase
      end
      if (res_valid && res.kind == KIND_STATUS) begin
        phase_nxt  = PH_MAGIC;
        cnt_nxt    = 3'd0;
        shift_nxt  = 64'h0;
        remain_nxt = 32'h0;
        crc_nxt    = CRC_INIT;
      end
    end
    if (cfg_valid && cfg_ready && cfg_index == CFG_BASE_POSITION) begin
      pos_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r    <= MAGIC_RST;
      max_pay_r  <= MAX_PAYLOAD_RST;
      phase_r    <= PH_MAGIC;
      cnt_r      <= 3'd0;
      shift_r    <= 64'h0;
      remain_r   <= 32'h0;
      crc_r      <= CRC_INIT;
      pos_r      <= BASE_POS_RST;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      shift_r  <= shift_nxt;
      remain_r <= remain_nxt;
      crc_r    <= crc_nxt;
      pos_r    <= pos_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_RECORD_MAGIC:  magic_r   <= cfg_wdata[31:0];
          CFG_MAX_PAYLOAD:   max_pay_r <= cfg_wdata[31:0];
          // stream position loaded through pos_nxt
          CFG_BASE_POSITION: ;
          default: ;
        endcase
      end
    end
  end

  // output register plus skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skd_valid_r <= 1'b0;
    end else if (!out_valid_r || out_fire) begin
      if (skd_valid_r) begin
        out_valid_r <= 1'b1;
        skd_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      out_r <= skd_valid_r ? skd_r : res;
    end else if (res_valid) begin
      skd_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_r.kind;
  assign out_payload_byte = out_r.payload_byte;
  assign out_last_payload = out_r.last_payload;
  assign out_status       = out_r.status;
  assign out_end_position = out_r.end_position;

endmodule
`default_nettype wire

@@ hdl/crd_checker.sv @@
// Port-level assertions for the record deframer, bound to the top level.
`default_nettype none
module crd_port_checks
  import crd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_kind,
  input wire logic [7:0]  out_payload_byte,
  input wire logic        out_last_payload,
  input wire logic [1:0]  out_status,
  input wire logic [63:0] out_end_position
);

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("output stage not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_status)
      && $stable(out_payload_byte) && $stable(out_end_position))
    else $error("stalled result changed");

  a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_PAYLOAD |-> out_status == ST_OK && out_end_position == 64'h0)
    else $error("payload result carries status fields");

  a_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_STATUS |-> out_payload_byte == 8'h00 && !out_last_payload
      && (out_status == ST_OK || out_status == ST_EOF || out_status == ST_INVALID))
    else $error("malformed status result");

  a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

endmodule

bind crc_record_deframer_core crd_port_checks u_crd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_kind         (out_kind),
  .out_payload_byte (out_payload_byte),
  .out_last_payload (out_last_payload),
  .out_status       (out_status),
  .out_end_position (out_end_position)
);
`default_nettype wire

@@ verif/crd_checker.sv @@
// Record deframer checker: mirrors the parser, holds the expected results and compares.
`timescale 1ns / 1ps
module crd_checker
  import crd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_end_of_input,
  input  logic [63:0]        in_expected_offset,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_kind,
  input  logic [7:0]         out_payload_byte,
  input  logic               out_last_payload,
  input  logic [1:0]         out_status,
  input  logic [63:0]        out_end_position,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [63:0]        cfg_wdata,
  output int unsigned        fail_count,
  output int unsigned        pending
);

  typedef enum logic [2:0] {
    PH_MAGIC, PH_OFFSET, PH_LENGTH, PH_PAYLOAD, PH_CRC
  } parse_phase_t;

  logic [31:0]  magic_word;
  logic [31:0]  payload_limit;
  parse_phase_t phase;
  int unsigned  field_cnt;
  logic [63:0]  field_acc;
  logic [63:0]  bytes_left;
  logic [31:0]  crc_acc;
  logic [63:0]  stream_pos;
  res_t         deframed_q[$];
  int unsigned  errs = 0;

  function automatic logic [31:0] crc32_next(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    int k;
    r = c;
    for (k = 0; k < 8; k++) r = {1'b0, r[31:1]} ^ ((r[0] ^ d[k]) ? CRC_POLY : 32'h0);
    return r;
  endfunction

  function automatic void restart_parse();
    phase      = PH_MAGIC;
    field_cnt  = 0;
    field_acc  = '0;
    bytes_left = '0;
    crc_acc    = CRC_INIT;
  endfunction

  function automatic void close_record(input logic [1:0] st);
    res_t r;
    r              = '0;
    r.kind         = KIND_STATUS;
    r.status       = st;
    r.end_position = stream_pos;
    deframed_q.push_back(r);
    restart_parse();
  endfunction

  // little-endian field assembly; true once n bytes are in
  function automatic logic field_done(input logic [7:0] b, input int unsigned n);
    field_acc = field_acc | ({56'h0, b} << (8 * field_cnt));
    field_cnt = field_cnt + 1;
    if (field_cnt == n) begin
      field_cnt = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void deframe(input logic [7:0] b, input logic eoi,
                                  input logic [63:0] want_off);
    res_t r;
    logic [63:0] v;
    if (eoi) begin
      close_record((phase == PH_MAGIC && field_cnt == 0) ? ST_EOF : ST_INVALID);
    end else begin
      stream_pos = stream_pos + 64'd1;
      case (phase)
        PH_MAGIC: begin
          if (field_done(b, 4)) begin
            v = field_acc;
            field_acc = '0;
            if (v[31:0] != magic_word) close_record(ST_INVALID);
            else phase = PH_OFFSET;
          end
        end
        PH_OFFSET: begin
          crc_acc = crc32_next(crc_acc, b);
          if (field_done(b, 8)) begin
            v = field_acc;
            field_acc = '0;
            if (v != want_off) close_record(ST_INVALID);
            else phase = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          crc_acc = crc32_next(crc_acc, b);
          if (field_done(b, 8)) begin
            v = field_acc;
            field_acc = '0;
            if (v > {32'h0, payload_limit}) begin
              close_record(ST_INVALID);
            end else begin
              bytes_left = v;
              phase = (v == 64'd0) ? PH_CRC : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          crc_acc = crc32_next(crc_acc, b);
          r = '0;
          r.kind = KIND_PAYLOAD;
          r.payload_byte = b;
          r.last_payload = (bytes_left <= 64'd1);
          deframed_q.push_back(r);
          if (bytes_left != 64'd0) bytes_left = bytes_left - 64'd1;
          if (bytes_left == 64'd0) phase = PH_CRC;
        end
        PH_CRC: begin
          if (field_done(b, 4)) begin
            v = field_acc;
            field_acc = '0;
            close_record((v[31:0] != ~crc_acc) ? ST_INVALID : ST_OK);
          end
        end
        default: close_record(ST_INVALID);
      endcase
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      magic_word    = MAGIC_RST;
      payload_limit = MAX_PAYLOAD_RST;
      stream_pos    = BASE_POS_RST;
      restart_parse();
      deframed_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RECORD_MAGIC:  magic_word    = cfg_wdata[31:0];
          CFG_MAX_PAYLOAD:   payload_limit = cfg_wdata[31:0];
          CFG_BASE_POSITION: stream_pos    = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) deframe(in_data_byte, in_end_of_input, in_expected_offset);
      if (out_valid && !out_stall) begin
        if (deframed_q.size() == 0) begin
          $error("result with nothing expected: kind %0d status %0d", out_kind, out_status);
          errs++;
        end else begin
          want = deframed_q.pop_front();
          check_field("kind", want.kind, out_kind);
          check_field("payload_byte", want.payload_byte, out_payload_byte);
          check_field("last_payload", want.last_payload, out_last_payload);
          check_field("status", want.status, out_status);
          check_field("end_position", want.end_position, out_end_position);
        end
      end
    end
    fail_count <= errs;
    pending    <= deframed_q.size();
  end

endmodule

@@ verif/tb_top.sv @@
// Testbench top for the record deframer: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import crd_pkg::*;

  typedef enum int {
    REC_GOOD, REC_BAD_MAGIC, REC_BAD_OFFSET, REC_TOO_LONG, REC_BAD_CRC,
    REC_CUT_SHORT, REC_END, REC_NOISE
  } rec_kind_t;

  localparam int unsigned QUIET_LIMIT = 4000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_data_byte = '0;
  logic               in_end_of_input = 1'b0;
  logic [63:0]        in_expected_offset = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_kind;
  logic [7:0]         out_payload_byte;
  logic               out_last_payload;
  logic [1:0]         out_status;
  logic [63:0]        out_end_position;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [63:0]        cfg_wdata = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_gap_pct = 35;
  int unsigned stall_pct = 68;
  int unsigned sent = 0;
  int unsigned quiet = 0;
  logic [31:0] cur_magic = MAGIC_RST;
  logic [31:0] cur_max = MAX_PAYLOAD_RST;

  always #5 clk = ~clk;

  crc_record_deframer_core u_top (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data_byte, .in_end_of_input, .in_expected_offset,
    .out_valid, .out_stall, .out_kind, .out_payload_byte, .out_last_payload,
    .out_status, .out_end_position,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_wdata
  );

  crd_checker u_chk (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data_byte, .in_end_of_input, .in_expected_offset,
    .out_valid, .out_stall, .out_kind, .out_payload_byte, .out_last_payload,
    .out_status, .out_end_position,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_wdata,
    .fail_count, .pending
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] crc_fold(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    int k;
    r = c ^ {24'h0, d};
    for (k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  task automatic push_item(input logic [7:0] b, input logic eoi, input logic [63:0] off);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_data_byte       <= b;
    in_end_of_input    <= eoi;
    in_expected_offset <= off;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // unused upper data bits carry noise on the 32-bit registers
  task automatic configure(input logic [31:0] magic, input logic [31:0] limit,
                           input logic [63:0] base);
    logic [CfgIdxW-1:0] idx [3];
    logic [63:0] val [3];
    int i;
    idx = '{CFG_RECORD_MAGIC, CFG_MAX_PAYLOAD, CFG_BASE_POSITION};
    val = '{{$urandom, magic}, {$urandom, limit}, base};
    for (i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    cur_magic = magic;
    cur_max   = limit;
  endtask

  task automatic send_record(input rec_kind_t kind, input int plen_req);
    logic [7:0] rec[$];
    logic [63:0] off, want_off, len;
    logic [31:0] magic, crc;
    int plen, stop, i;
    magic = cur_magic;
    if (kind == REC_BAD_MAGIC) magic ^= 32'h1 << $urandom_range(31);
    off = rand64();
    want_off = off;
    if (kind == REC_BAD_OFFSET) want_off ^= 64'h1 << $urandom_range(63);
    if (plen_req >= 0) plen = plen_req;
    else if (cur_max == 0) plen = 0;
    else if (cur_max <= 32 && $urandom_range(4) == 0) plen = cur_max;
    else plen = $urandom_range((cur_max < 16) ? cur_max : 16);
    len = plen;
    if (kind == REC_TOO_LONG) begin
      len = $urandom_range(1) ? ({32'h0, cur_max} + 64'd1) : (rand64() | 64'h1_0000_0000);
    end
    for (i = 0; i < 4; i++) rec.push_back(magic[8*i +: 8]);
    for (i = 0; i < 8; i++) rec.push_back(off[8*i +: 8]);
    for (i = 0; i < 8; i++) rec.push_back(len[8*i +: 8]);
    for (i = 0; i < plen; i++) rec.push_back(8'($urandom));
    crc = CRC_INIT;
    for (i = 4; i < rec.size(); i++) crc = crc_fold(crc, rec[i]);
    crc = ~crc;
    if (kind == REC_BAD_CRC) crc ^= 32'h1 << $urandom_range(31);
    for (i = 0; i < 4; i++) rec.push_back(crc[8*i +: 8]);
    if (kind == REC_NOISE) begin
      rec.delete();
      repeat ($urandom_range(12, 1)) rec.push_back(8'($urandom));
    end
    case (kind)
      REC_BAD_MAGIC:  stop = 4;
      REC_BAD_OFFSET: stop = 12;
      REC_TOO_LONG:   stop = 20;
      REC_CUT_SHORT:  stop = $urandom_range(rec.size() - 1, 1);
      REC_END:        stop = 0;
      default:        stop = rec.size();
    endcase
    for (i = 0; i < stop; i++) push_item(rec[i], 1'b0, (i == 11) ? want_off : rand64());
    if (kind == REC_CUT_SHORT || kind == REC_END || kind == REC_NOISE) begin
      push_item(8'($urandom), 1'b1, rand64());
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned stop_at, p;
    rec_kind_t kind;
    stop_at = sent + count;
    while (sent < stop_at) begin
      p = $urandom_range(99);
      if (p < 40) kind = REC_GOOD;
      else if (p < 50) kind = REC_BAD_MAGIC;
      else if (p < 62) kind = REC_BAD_OFFSET;
      else if (p < 74) kind = REC_TOO_LONG;
      else if (p < 86) kind = REC_BAD_CRC;
      else if (p < 94) kind = REC_CUT_SHORT;
      else if (p < 97) kind = REC_END;
      else kind = REC_NOISE;
      send_record(kind, -1);
    end
  endtask

  initial begin
    int i;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults: end at boundary, all-ones bad magic, empty payload, early end
    send_record(REC_END, -1);
    for (i = 0; i < 4; i++) push_item(8'hFF, 1'b0, '1);
    send_record(REC_GOOD, 0);
    send_record(REC_CUT_SHORT, -1);
    run_random(60);

    // position wraps early in this phase
    settle();
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF0);
    run_random(150);

    settle();
    send_gap_pct = 68;
    stall_pct    = 35;
    configure(32'h0000_0000, 32'h0000_0000, 64'h0);
    run_random(150);

    settle();
    send_gap_pct = 0;
    stall_pct    = 0;
    configure($urandom, $urandom_range(24, 1), rand64());
    run_random(160);

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
hdl/crd_pkg.sv
hdl/crc_record_deframer_core.sv
hdl/crd_checker.sv
verif/crd_checker.sv
verif/tb_top.sv
